[hw/rtl/mhft_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mhft_pkg;

    localparam int FRAME_BITS = 21;
    localparam int POS_W      = 5;
    localparam int TICK_W     = 24;
    localparam int ID_W       = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 24;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ID_SELECT      = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_BIT_TICKS = 1'd1;

    // 20 Hz bit rate in a 1000000-unit time base
    localparam logic [TICK_W-1:0] HALF_BIT_TICKS_RST = TICK_W'(25000);

    localparam logic [ID_W-1:0] ID_IDLE = 3'd0;
    localparam logic [ID_W-1:0] ID_ONE  = 3'd1;
    localparam logic [ID_W-1:0] ID_TWO  = 3'd2;
    localparam logic [ID_W-1:0] ID_THREE = 3'd3;
    localparam logic [ID_W-1:0] ID_FOUR = 3'd4;

    typedef logic [FRAME_BITS-1:0] frame_t;

    typedef struct packed {
        logic             led_red;
        logic             led_green;
        logic             led_blue;
        logic [POS_W-1:0] bit_number;
        logic             frame_end;
    } mhft_result_t;

    function automatic logic id_is_valid(input logic [ID_W-1:0] id);
        return (id >= ID_ONE) && (id <= ID_FOUR);
    endfunction

    // start 0101, ID bits repeated as LED bits, end 1010, Hamming parity
    function automatic frame_t build_frame(input logic [ID_W-1:0] id);
        frame_t d;
        logic   hi;
        logic   lo;
        hi = (id == ID_THREE) || (id == ID_FOUR);
        lo = (id == ID_TWO) || (id == ID_FOUR);
        d = '0;
        d[4]  = 1'b1;
        d[6]  = 1'b1;
        d[10] = hi;
        d[12] = hi;
        d[11] = lo;
        d[13] = lo;
        d[17] = 1'b1;
        d[19] = 1'b1;
        d[0]  = d[2] ^ d[4] ^ d[6] ^ d[8] ^ d[10] ^ d[12] ^ d[14] ^ d[16] ^ d[18] ^ d[20];
        d[1]  = d[2] ^ d[5] ^ d[6] ^ d[9] ^ d[10] ^ d[13] ^ d[14] ^ d[17] ^ d[18];
        d[3]  = d[4] ^ d[5] ^ d[6] ^ d[11] ^ d[12] ^ d[13] ^ d[14] ^ d[19] ^ d[20];
        d[7]  = d[8] ^ d[9] ^ d[10] ^ d[11] ^ d[12] ^ d[13] ^ d[14];
        d[15] = d[16] ^ d[17] ^ d[18] ^ d[19] ^ d[20];
        return d;
    endfunction

    // {blue, green, red} for the colored half-bit
    function automatic logic [2:0] id_colour(input logic [ID_W-1:0] id);
        logic r;
        logic g;
        logic b;
        r = (id == ID_TWO) || (id == ID_THREE);
        g = (id == ID_ONE) || (id == ID_THREE);
        b = (id == ID_ONE) || (id == ID_TWO);
        return {b, g, r};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/mhft_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module mhft_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic                        advance,
    input  wire logic                        restart,
    input  wire logic [mhft_pkg::ID_W-1:0]   id_select,
    input  wire logic [mhft_pkg::TICK_W-1:0] half_bit_ticks,
    output mhft_pkg::mhft_result_t           res
);
    import mhft_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BITS - 1);

    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic              second_half_reg, second_half_next;
    logic [POS_W-1:0]  bit_pos_reg, bit_pos_next;

    frame_t            frame_word;
    logic [TICK_W-1:0] ht_eff;
    logic              last_tick;
    logic              id_ok;
    logic              cur_bit;
    logic [2:0]        colour;

    assign frame_word = build_frame(id_select);
    assign id_ok      = id_is_valid(id_select);
    assign ht_eff     = (half_bit_ticks == '0) ? TICK_W'(1) : half_bit_ticks;
    assign last_tick  = tick_count_reg >= (ht_eff - TICK_W'(1));
    assign cur_bit    = frame_word[bit_pos_reg];
    assign colour     = id_colour(id_select);

    // result reflects the state before this request's tick
    always_comb
    begin
        res = '0;
        res.led_red   = 1'b1;
        res.led_green = 1'b1;
        res.led_blue  = 1'b1;
        if (id_ok)
        begin
            if (cur_bit == second_half_reg)
            begin
                res.led_red   = colour[0];
                res.led_green = colour[1];
                res.led_blue  = colour[2];
            end
            res.bit_number = bit_pos_reg;
            res.frame_end  = second_half_reg && last_tick && (bit_pos_reg == LAST_POS);
        end
    end

    always_comb
    begin
        tick_count_next  = tick_count_reg;
        second_half_next = second_half_reg;
        bit_pos_next     = bit_pos_reg;
        if (restart)
        begin
            tick_count_next  = '0;
            second_half_next = 1'b0;
            bit_pos_next     = '0;
        end
        else if (step)
        begin
            if (!id_ok)
            begin
                tick_count_next  = '0;
                second_half_next = 1'b0;
                bit_pos_next     = '0;
            end
            else if (advance)
            begin
                if (last_tick)
                begin
                    tick_count_next = '0;
                    if (second_half_reg)
                    begin
                        second_half_next = 1'b0;
                        bit_pos_next = (bit_pos_reg == LAST_POS) ? '0
                                                                : bit_pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        second_half_next = 1'b1;
                    end
                end
                else
                begin
                    tick_count_next = tick_count_reg + TICK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            second_half_reg <= 1'b0;
            bit_pos_reg     <= '0;
        end
        else
        begin
            tick_count_reg  <= tick_count_next;
            second_half_reg <= second_half_next;
            bit_pos_reg     <= bit_pos_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_pos_reg <= LAST_POS)
        else $error("bit position past end of frame");

    a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !id_ok) |=> (tick_count_reg == '0 && !second_half_reg && bit_pos_reg == '0))
        else $error("counters not cleared while idle");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!step && !restart) |=> ($stable(tick_count_reg) && $stable(bit_pos_reg)
                                 && $stable(second_half_reg)))
        else $error("state moved without a request");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (step && advance && !restart && res.frame_end) |=> (bit_pos_reg == '0))
        else $error("frame did not wrap after its last tick");

endmodule

`default_nettype wire

[hw/rtl/manchester_hamming_frame_tx.sv]
`timescale 1ns / 1ps
`default_nettype none

// A result appears on m_tvalid in the cycle after its request is taken.
// Throughput: one request per cycle unless held by s_tready = !m_tvalid || m_tready;
// the single output register is the only stage between the two sides.
// Reset (async, active low): idle ID, 25000 ticks per half-bit, counters at bit 0,
// output register empty.
module manchester_hamming_frame_tx (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [7:0]                      s_tdata,   // [0] advance
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [7:0]                      m_tdata,   // [0] led_red, [1] led_green,
                                                            // [2] led_blue, [7:3] bit_number
    output      logic                            m_tlast,   // frame_end
    input  wire logic                            cfg_we,
    input  wire logic [mhft_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [mhft_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mhft_pkg::*;

    logic [ID_W-1:0]   id_select_reg;
    logic [TICK_W-1:0] half_bit_ticks_reg;
    logic              out_valid_reg;
    mhft_result_t      out_reg;
    mhft_result_t      res;
    logic              accept;
    logic              restart;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign restart  = cfg_we && (cfg_addr == REG_ID_SELECT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_select_reg      <= ID_IDLE;
            half_bit_ticks_reg <= HALF_BIT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ID_SELECT:      id_select_reg      <= cfg_data[ID_W-1:0];
                REG_HALF_BIT_TICKS: half_bit_ticks_reg <= cfg_data[TICK_W-1:0];
                default:            ;
            endcase
        end
    end

    mhft_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (accept),
        .advance        (s_tdata[0]),
        .restart        (restart),
        .id_select      (id_select_reg),
        .half_bit_ticks (half_bit_ticks_reg),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.bit_number, out_reg.led_blue, out_reg.led_green,
                       out_reg.led_red};
    assign m_tlast  = out_reg.frame_end;

    a_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[7:3] == POS_W'(FRAME_BITS - 1)))
        else $error("frame end reported away from the last bit");

    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted request produced no result");

    a_idle_white: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !id_is_valid(id_select_reg) && !cfg_we)
            |=> (m_tdata == 8'h07 && !m_tlast))
        else $error("idle result is not plain white");

endmodule

`default_nettype wire
